FILE: rtl/bda_pkg.sv
package bda_pkg;

  // Width of the binary input value.
  localparam int unsigned VALUE_W = 31;

  // Bytes of the output text.
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_EOT   = 8'd4;
  localparam logic [7:0] BYTE_LF    = 8'd10;

  // Control of the BCD shift register by the sequencer.
  typedef struct packed {
    logic clear;     // zero the digits and the overflow flag
    logic step;      // one double dabble step
    logic in_bit;    // binary bit shifted in on a step
    logic saturate;  // force all digits to nine
    logic shift;     // drop the top digit, shift the rest up
  } bda_ctrl_t;

endpackage

FILE: rtl/bda_if.sv
interface bda_in_if;
  logic                          valid;
  logic                          ready;
  logic [bda_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface bda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

FILE: rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII text converter.
//
// in_i takes one request: a 31-bit non-negative integer. out_o returns the
// text as a run of bytes: the decimal digits, most significant first and
// without leading zeros, then carriage return, end-of-transmission and line
// feed. last is high on the line feed. A value that needs more than
// MAX_DIGITS digits comes out as MAX_DIGITS nines.
//
// The conversion is a bit-serial double dabble: the value is shifted into a
// BCD register one bit per cycle; then the overflow check runs, leading zero
// digits are dropped one at a time and the zero scan ends, after which the
// digit and terminator bytes follow one per cycle while the receiver is
// ready. in_i is ready again in the cycle after the line feed is taken.
// A stalled receiver holds the current byte and stops the sequence; nothing
// is dropped. Reset empties the output register and returns to idle.
module binary_to_decimal_ascii #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bda_in_if.sink     in_i,
  bda_out_if.source  out_o
);

  localparam int unsigned BIT_W  = $clog2(bda_pkg::VALUE_W);
  localparam int unsigned NDIG_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIX,
    ST_SKIP,
    ST_EMIT,
    ST_TERM,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    TERM_CR,
    TERM_EOT,
    TERM_LF
  } term_e;

  state_e                      state_q;
  term_e                       term_q;
  logic [bda_pkg::VALUE_W-1:0] shreg_q;
  logic [BIT_W-1:0]            bitcnt_q;
  logic [NDIG_W-1:0]           ndig_q;
  logic                        out_valid_q;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q;

  bda_pkg::bda_ctrl_t          ctrl;
  logic [3:0]                  top_digit;
  logic                        ovf;
  logic                        out_free;
  logic                        skip_zero;

  assign out_free  = !out_valid_q || out_o.ready;
  assign skip_zero = (top_digit == 4'd0) && (ndig_q != NDIG_W'(1));

  always_comb begin
    ctrl          = '0;
    ctrl.clear    = (state_q == ST_IDLE) && in_i.valid;
    ctrl.step     = (state_q == ST_CONV);
    ctrl.in_bit   = shreg_q[bda_pkg::VALUE_W-1];
    ctrl.saturate = (state_q == ST_FIX) && ovf;
    ctrl.shift    = ((state_q == ST_SKIP) && skip_zero) ||
                    ((state_q == ST_EMIT) && out_free);
  end

  bda_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .top_digit_o(top_digit),
    .ovf_o      (ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_CR;
      bitcnt_q    <= '0;
      ndig_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            bitcnt_q <= '0;
            state_q  <= ST_CONV;
          end
        end
        ST_CONV: begin
          bitcnt_q <= bitcnt_q + BIT_W'(1);
          if (bitcnt_q == BIT_W'(bda_pkg::VALUE_W - 1)) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          ndig_q  <= NDIG_W'(MAX_DIGITS);
          state_q <= ST_SKIP;
        end
        ST_SKIP: begin
          if (skip_zero) begin
            ndig_q <= ndig_q - NDIG_W'(1);
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= bda_pkg::ASCII_ZERO + {4'd0, top_digit};
            out_last_q  <= 1'b0;
            ndig_q      <= ndig_q - NDIG_W'(1);
            if (ndig_q == NDIG_W'(1)) begin
              term_q  <= TERM_CR;
              state_q <= ST_TERM;
            end
          end
        end
        ST_TERM: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            unique case (term_q)
              TERM_CR: begin
                out_byte_q <= bda_pkg::BYTE_CR;
                out_last_q <= 1'b0;
                term_q     <= TERM_EOT;
              end
              TERM_EOT: begin
                out_byte_q <= bda_pkg::BYTE_EOT;
                out_last_q <= 1'b0;
                term_q     <= TERM_LF;
              end
              TERM_LF: begin
                out_byte_q <= bda_pkg::BYTE_LF;
                out_last_q <= 1'b1;
                state_q    <= ST_DONE;
              end
              default: begin
                term_q <= TERM_CR;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The input is loaded straight into the serial shift register.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_i.valid) begin
      shreg_q <= in_i.value;
    end else if (state_q == ST_CONV) begin
      shreg_q <= shreg_q << 1;
    end
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

  // A new request is only taken once the previous run has fully drained.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input ready while a byte is still pending");

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.out_byte == bda_pkg::BYTE_LF))
    else $error("last flag on a byte other than line feed");

  a_emit_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (state_q == ST_EMIT)) |->
      ((out_o.out_byte >= bda_pkg::ASCII_ZERO) &&
       (out_o.out_byte <= bda_pkg::ASCII_ZERO + 8'd9)))
    else $error("non-digit byte during digit output");

  a_conv_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CONV) || (state_q == ST_SKIP)) |-> !out_o.valid)
    else $error("output valid during conversion");

  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SKIP) || (state_q == ST_EMIT)) |-> (ndig_q != '0))
    else $error("digit counter ran out");

endmodule

FILE: rtl/bda_dabble.sv
module bda_dabble #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bda_pkg::bda_ctrl_t ctrl_i,
  output logic [3:0]        top_digit_o,
  output logic              ovf_o
);

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;

  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BCD_W-1:0] adj;
  logic             ovf_q, ovf_d;

  // Add three to every digit of five or more before the doubling shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bcd_d = bcd_q;
    ovf_d = ovf_q;
    priority if (ctrl_i.clear) begin
      bcd_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.step) begin
      bcd_d = {adj[BCD_W-2:0], ctrl_i.in_bit};
      // A bit leaving the top digit means the value needs more digits.
      ovf_d = ovf_q | adj[BCD_W-1];
    end else if (ctrl_i.saturate) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        bcd_d[4*i +: 4] = 4'd9;
      end
    end else if (ctrl_i.shift) begin
      bcd_d = bcd_q << 4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign top_digit_o = bcd_q[BCD_W-1 -: 4];
  assign ovf_o       = ovf_q;

endmodule
